FILE: design/irpd_pkg.sv
`timescale 1ns / 1ps

package irpd_pkg;

    localparam int WORD_WIDTH = 32;
    localparam int CNT_W      = $clog2(WORD_WIDTH + 1);
    localparam int OUT_W      = 32;
    localparam int PW_W       = 24;
    localparam int NOM_W      = 16;
    localparam int IDLE_W     = 10;
    localparam int TOL_W      = 7;
    localparam int GRP_W      = 6;
    localparam int KIND_W     = 2;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DAT_W  = 16;
    localparam int PT_W       = 3;
    localparam int Q_DEPTH    = 4;
    localparam int Q_PTR_W    = $clog2(Q_DEPTH);
    localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DATA_BURST = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_SPACE = 4'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_SPACE  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] REG_IDLE_LIMIT = 4'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE  = 4'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GROUP_BITS = 4'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SKIP_HDR   = 4'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT_PACK = 4'd7;

    // register reset values
    localparam logic [NOM_W-1:0]  RST_DATA_BURST = 16'd560;
    localparam logic [NOM_W-1:0]  RST_ZERO_SPACE = 16'd560;
    localparam logic [NOM_W-1:0]  RST_ONE_SPACE  = 16'd1690;
    localparam logic [IDLE_W-1:0] RST_IDLE_LIMIT = 10'd20;
    localparam logic [TOL_W-1:0]  RST_TOLERANCE  = 7'd25;
    localparam logic [GRP_W-1:0]  RST_GROUP_BITS = 6'd8;

    // pulse classes
    localparam logic [PT_W-1:0] PT_INVALID    = 3'd0;
    localparam logic [PT_W-1:0] PT_DATA       = 3'd1;
    localparam logic [PT_W-1:0] PT_BIT0       = 3'd2;
    localparam logic [PT_W-1:0] PT_BIT1       = 3'd3;
    localparam logic [PT_W-1:0] PT_LONG_SPACE = 3'd4;
    localparam logic [PT_W-1:0] PT_LONG_BURST = 3'd5;
    localparam logic [PT_W-1:0] PT_IDLE       = 3'd6;

    // result kinds
    localparam logic [KIND_W-1:0] K_DATA    = 2'd0;
    localparam logic [KIND_W-1:0] K_HEADER  = 2'd1;
    localparam logic [KIND_W-1:0] K_SPACE   = 2'd2;
    localparam logic [KIND_W-1:0] K_UNKNOWN = 2'd3;

    typedef struct packed {
        logic [NOM_W-1:0]  data_burst_us;
        logic [NOM_W-1:0]  zero_space_us;
        logic [NOM_W-1:0]  one_space_us;
        logic [IDLE_W-1:0] idle_limit_ms;
        logic [TOL_W-1:0]  tolerance_percent;
        logic [GRP_W-1:0]  group_bits;
        logic              skip_header;
        logic              shift_packing;
    } t_cfg;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [OUT_W-1:0]  word;
        logic              last;
    } t_result;

    typedef struct packed {
        logic [1:0] n;
        t_result    r0;
        t_result    r1;
    } t_step;

    typedef struct packed {
        logic [Q_CNT_W-1:0] count;
        logic               room2;
    } t_q_stat;

endpackage

FILE: design/irpd_if.sv
`timescale 1ns / 1ps

interface irpd_pulse_if import irpd_pkg::*; ();
    logic            valid;
    logic            ready;
    logic            is_mark;
    logic [PW_W-1:0] pulse_width;

    modport source (output valid, is_mark, pulse_width, input ready);
    modport sink (input valid, is_mark, pulse_width, output ready);
endinterface

interface irpd_result_if import irpd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [OUT_W-1:0]  word;
    logic              last;

    modport source (output valid, kind, word, last, input ready);
    modport sink (input valid, kind, word, last, output ready);
endinterface

interface irpd_cfg_if import irpd_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

FILE: design/irpd_cfg_regs.sv
`timescale 1ns / 1ps

module irpd_cfg_regs import irpd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    irpd_cfg_if.sink   i_cfg,
    output t_cfg       o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign i_cfg.ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_DATA_BURST: n_cfg.data_burst_us     = i_cfg.data;
                REG_ZERO_SPACE: n_cfg.zero_space_us     = i_cfg.data;
                REG_ONE_SPACE:  n_cfg.one_space_us      = i_cfg.data;
                REG_IDLE_LIMIT: n_cfg.idle_limit_ms     = i_cfg.data[IDLE_W-1:0];
                REG_TOLERANCE:  n_cfg.tolerance_percent = i_cfg.data[TOL_W-1:0];
                REG_GROUP_BITS: n_cfg.group_bits        = i_cfg.data[GRP_W-1:0];
                REG_SKIP_HDR:   n_cfg.skip_header       = i_cfg.data[0];
                REG_SHIFT_PACK: n_cfg.shift_packing     = i_cfg.data[0];
                default:        n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.data_burst_us     <= RST_DATA_BURST;
            r_cfg.zero_space_us     <= RST_ZERO_SPACE;
            r_cfg.one_space_us      <= RST_ONE_SPACE;
            r_cfg.idle_limit_ms     <= RST_IDLE_LIMIT;
            r_cfg.tolerance_percent <= RST_TOLERANCE;
            r_cfg.group_bits        <= RST_GROUP_BITS;
            r_cfg.skip_header       <= 1'b0;
            r_cfg.shift_packing     <= 1'b0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: design/irpd_classify.sv
`timescale 1ns / 1ps

module irpd_classify import irpd_pkg::*; (
    input  t_cfg            i_cfg,
    input  logic            i_is_mark,
    input  logic [PW_W-1:0] i_pulse_width,
    output logic [PT_W-1:0] o_class
);

    localparam int PROD_W = NOM_W + 8;
    localparam int W100_W = PW_W + 7;
    localparam int IDL_W  = IDLE_W + 10;

    logic [TOL_W-1:0]  low_f;
    logic [7:0]        high_f;
    logic [W100_W-1:0] w100;
    logic [PROD_W-1:0] lo_data, lo_zero, lo_one;
    logic [PROD_W-1:0] hi_data, hi_zero, hi_one;
    logic [IDL_W-1:0]  idle_thr;
    logic              below_data, below_zero, below_one;
    logic              above_data, above_zero, above_one;
    logic              too_short, is_idle;

    assign low_f  = (i_cfg.tolerance_percent > 7'd100) ? '0
                  : 7'(7'd100 - i_cfg.tolerance_percent);
    assign high_f = 8'd100 + 8'(i_cfg.tolerance_percent);
    assign w100   = W100_W'(i_pulse_width) * W100_W'(100);

    assign lo_data = PROD_W'(i_cfg.data_burst_us) * PROD_W'(low_f);
    assign lo_zero = PROD_W'(i_cfg.zero_space_us) * PROD_W'(low_f);
    assign lo_one  = PROD_W'(i_cfg.one_space_us) * PROD_W'(low_f);
    assign hi_data = PROD_W'(i_cfg.data_burst_us) * PROD_W'(high_f);
    assign hi_zero = PROD_W'(i_cfg.zero_space_us) * PROD_W'(high_f);
    assign hi_one  = PROD_W'(i_cfg.one_space_us) * PROD_W'(high_f);

    assign below_data = w100 < W100_W'(lo_data);
    assign below_zero = w100 < W100_W'(lo_zero);
    assign below_one  = w100 < W100_W'(lo_one);
    assign above_data = w100 > W100_W'(hi_data);
    assign above_zero = w100 > W100_W'(hi_zero);
    assign above_one  = w100 > W100_W'(hi_one);

    // below the smallest lower bound means below all of them
    assign too_short = below_data && below_zero && below_one;
    assign idle_thr  = IDL_W'(i_cfg.idle_limit_ms) * IDL_W'(1000);
    assign is_idle   = i_pulse_width >= PW_W'(idle_thr);

    always_comb begin
        priority if (too_short) begin
            o_class = PT_INVALID;
        end else if (i_is_mark) begin
            priority if (!below_data && !above_data) begin
                o_class = PT_DATA;
            end else if (above_data) begin
                o_class = PT_LONG_BURST;
            end else begin
                o_class = PT_INVALID;
            end
        end else if (is_idle) begin
            o_class = PT_IDLE;
        end else if (!below_zero && !above_zero) begin
            o_class = PT_BIT0;
        end else if (!below_one && !above_one) begin
            o_class = PT_BIT1;
        end else if (above_zero && above_one) begin
            o_class = PT_LONG_SPACE;
        end else begin
            o_class = PT_INVALID;
        end
    end

endmodule

FILE: design/irpd_frame_fsm.sv
`timescale 1ns / 1ps

module irpd_frame_fsm import irpd_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_cfg            i_cfg,
    input  logic            i_fire,
    input  logic [PT_W-1:0] i_class,
    output t_step           o_step
);

    localparam logic [2:0] ST_IDLE        = 3'd0;
    localparam logic [2:0] ST_HDR_STARTED = 3'd1;
    localparam logic [2:0] ST_HDR_SYNCED  = 3'd2;
    localparam logic [2:0] ST_DATA_WAIT   = 3'd3;
    localparam logic [2:0] ST_DATA_REC    = 3'd4;
    localparam logic [2:0] ST_ERROR       = 3'd5;

    logic [2:0]            r_state, n_state;
    logic [WORD_WIDTH-1:0] r_acc, n_acc;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic                  r_lwh, n_lwh;

    logic                  do_emit, do_append;
    logic [KIND_W-1:0]     emit_kind;
    logic                  is_bit, bit_val;
    logic [CNT_W-1:0]      group;
    logic [CNT_W-1:0]      cnt_inc;
    logic [WORD_WIDTH-1:0] acc_new;
    t_step                 step;

    assign is_bit  = (i_class == PT_BIT0) || (i_class == PT_BIT1);
    assign bit_val = (i_class == PT_BIT1);

    always_comb begin
        if (i_cfg.group_bits == '0) begin
            group = CNT_W'(8);
        end else if (32'(i_cfg.group_bits) > 32'(WORD_WIDTH)) begin
            group = CNT_W'(WORD_WIDTH);
        end else begin
            group = CNT_W'(i_cfg.group_bits);
        end
    end

    assign cnt_inc = r_cnt + CNT_W'(1);

    always_comb begin
        if (i_cfg.shift_packing) begin
            acc_new = {r_acc[WORD_WIDTH-2:0], bit_val};
        end else begin
            acc_new = r_acc | (WORD_WIDTH'(bit_val) << r_cnt);
        end
    end

    // frame transitions
    always_comb begin
        n_state   = r_state;
        do_emit   = 1'b0;
        do_append = 1'b0;
        emit_kind = K_SPACE;
        unique case (r_state)
            ST_IDLE, ST_HDR_STARTED: begin
                priority if (r_state == ST_HDR_STARTED && i_class == PT_IDLE) begin
                    n_state = ST_IDLE;
                    do_emit = 1'b1;
                end else if (i_class == PT_LONG_SPACE || i_class == PT_DATA) begin
                    n_state   = ST_HDR_SYNCED;
                    do_emit   = 1'b1;
                    emit_kind = K_HEADER;
                end else if (r_state == ST_IDLE && i_class == PT_LONG_BURST) begin
                    n_state = ST_HDR_STARTED;
                end else if (is_bit) begin
                    if (i_cfg.skip_header) begin
                        do_append = 1'b1;
                    end else begin
                        n_state   = ST_HDR_SYNCED;
                        do_emit   = 1'b1;
                        emit_kind = K_HEADER;
                    end
                end else begin
                    n_state = r_state;
                end
            end
            ST_HDR_SYNCED: begin
                if (i_class == PT_IDLE) begin
                    n_state = ST_IDLE;
                    do_emit = 1'b1;
                end else if (is_bit) begin
                    do_append = 1'b1;
                end
            end
            ST_DATA_WAIT: begin
                if (i_class == PT_IDLE) begin
                    n_state = ST_IDLE;
                    do_emit = 1'b1;
                end else if (i_class == PT_DATA) begin
                    n_state = ST_DATA_REC;
                end else begin
                    n_state = ST_ERROR;
                end
            end
            ST_DATA_REC: begin
                if (i_class == PT_IDLE) begin
                    n_state = ST_IDLE;
                    do_emit = 1'b1;
                end else if (is_bit) begin
                    do_append = 1'b1;
                end else begin
                    n_state   = ST_ERROR;
                    do_emit   = 1'b1;
                    emit_kind = K_UNKNOWN;
                end
            end
            default: begin
                n_state = ST_ERROR;
                if (i_class == PT_IDLE) begin
                    n_state = ST_IDLE;
                    do_emit = 1'b1;
                end
            end
        endcase
        if (do_append) begin
            n_state = ST_DATA_WAIT;
        end
    end

    // results and accumulator update
    always_comb begin
        n_acc   = r_acc;
        n_cnt   = r_cnt;
        n_lwh   = r_lwh;
        step    = '0;
        if (do_emit && !(emit_kind == K_HEADER && r_lwh)) begin
            if (r_cnt != '0) begin
                step.n       = 2'd2;
                step.r0.kind = K_UNKNOWN;
                step.r1.kind = emit_kind;
                step.r1.last = 1'b1;
                n_acc        = '0;
                n_cnt        = '0;
            end else begin
                step.n       = 2'd1;
                step.r0.kind = emit_kind;
                step.r0.last = 1'b1;
            end
            n_lwh = (emit_kind == K_HEADER);
        end else if (do_append) begin
            if (cnt_inc >= group) begin
                step.n       = 2'd1;
                step.r0.kind = K_DATA;
                step.r0.word = OUT_W'(acc_new);
                step.r0.last = 1'b1;
                n_acc        = '0;
                n_cnt        = '0;
                n_lwh        = 1'b0;
            end else begin
                n_acc = acc_new;
                n_cnt = cnt_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_acc   <= '0;
            r_cnt   <= '0;
            r_lwh   <= 1'b0;
        end else if (i_fire) begin
            r_state <= n_state;
            r_acc   <= n_acc;
            r_cnt   <= n_cnt;
            r_lwh   <= n_lwh;
        end
    end

    always_comb begin
        o_step = step;
        if (!i_fire) begin
            o_step.n = 2'd0;
        end
    end

endmodule

FILE: design/irpd_out_queue.sv
`timescale 1ns / 1ps

module irpd_out_queue import irpd_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_step         i_step,
    irpd_result_if.source o_result,
    output t_q_stat       o_stat
);

    t_result            r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr, r_rd;
    logic [Q_CNT_W-1:0] r_count;
    logic               pop;

    assign o_result.valid = (r_count != '0);
    assign o_result.kind  = r_mem[r_rd].kind;
    assign o_result.word  = r_mem[r_rd].word;
    assign o_result.last  = r_mem[r_rd].last;
    assign pop            = o_result.valid && o_result.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + Q_PTR_W'(i_step.n);
            r_rd    <= r_rd + Q_PTR_W'(pop);
            r_count <= r_count + Q_CNT_W'(i_step.n) - Q_CNT_W'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step.n != 2'd0) begin
            r_mem[r_wr] <= i_step.r0;
        end
        if (i_step.n == 2'd2) begin
            r_mem[r_wr + Q_PTR_W'(1)] <= i_step.r1;
        end
    end

    assign o_stat.count = r_count;
    assign o_stat.room2 = (r_count <= Q_CNT_W'(Q_DEPTH - 2));

endmodule

FILE: design/ir_pulse_distance_decoder_top.sv
`timescale 1ns / 1ps

// IR pulse-distance decoder
// i_pulse: one transaction per measured pulse (is_mark, pulse_width in us).
// o_result: decoded symbols (kind, word, last); last marks the final result
//   caused by one pulse, which yields zero, one or two results.
// i_cfg: register writes (index, data), always ready, applied on the next
//   clock; write only while no pulse is in flight or results are pending.
// Path: a pulse accepted on i_pulse is held in the input register,
//   classified combinationally and stepped through the frame state
//   machine when it fires; its results are written into the output queue,
//   which offers them on o_result.
// Throughput: one pulse per cycle while the queue has two free entries. The
//   output port moves one result per cycle while o_result.ready is high.
// Stalls: results wait in a four-entry queue. A pulse is stepped only when
//   two entries are free; otherwise it is held in the input register and
//   i_pulse.ready drops until o_result.ready drains the queue.
// Reset: synchronous, active low. Registers return to their defaults, the
//   frame state goes idle with no pending bits and the queue empties.

module ir_pulse_distance_decoder_top import irpd_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    irpd_pulse_if.sink    i_pulse,
    irpd_cfg_if.sink      i_cfg,
    irpd_result_if.source o_result
);

    t_cfg            cfg;
    t_step           step;
    t_q_stat         q_stat;
    logic [PT_W-1:0] pulse_class;
    logic            fire;

    logic            r_in_valid;
    logic            r_is_mark;
    logic [PW_W-1:0] r_pulse_width;

    assign fire          = r_in_valid && q_stat.room2;
    assign i_pulse.ready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_pulse.ready) begin
            r_in_valid <= i_pulse.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_pulse.valid && i_pulse.ready) begin
            r_is_mark     <= i_pulse.is_mark;
            r_pulse_width <= i_pulse.pulse_width;
        end
    end

    irpd_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    irpd_classify u_classify (
        .i_cfg         (cfg),
        .i_is_mark     (r_is_mark),
        .i_pulse_width (r_pulse_width),
        .o_class       (pulse_class)
    );

    irpd_frame_fsm u_fsm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_fire  (fire),
        .i_class (pulse_class),
        .o_step  (step)
    );

    irpd_out_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .o_result (o_result),
        .o_stat   (q_stat)
    );

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_stat.count <= Q_CNT_W'(Q_DEPTH))
        else $error("result queue overflow");

    a_valid_tracks_queue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid == (q_stat.count != '0))
        else $error("result valid disagrees with queue fill");

    a_stall_only_when_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_pulse.ready |-> (r_in_valid && !q_stat.room2))
        else $error("input stalled without a held pulse");

    a_results_need_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step.n != 2'd0) |-> fire)
        else $error("results pushed without a stepped pulse");

    a_pair_ends_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (step.n == 2'd2) |-> (step.r1.last && !step.r0.last))
        else $error("two-result step with wrong last marks");

endmodule

FILE: sim/tb_ir_pulse_distance_decoder_top.sv
`timescale 1ns / 1ps

module tb_ir_pulse_distance_decoder_top;
    import irpd_pkg::*;

    typedef enum logic [2:0] {
        FS_IDLE,
        FS_HDR_STARTED,
        FS_HDR_SYNCED,
        FS_DATA_WAIT,
        FS_DATA_REC,
        FS_ERROR
    } t_frame_state;

    class ir_symbol_scoreboard;
        t_cfg                  cfg;
        t_frame_state          state;
        logic [WORD_WIDTH-1:0] acc;
        int unsigned           nbits;
        bit                    hdr_last;
        t_result               step_out[$];
        t_result               expected_symbols[$];
        int                    errors;

        function new();
            cfg = '{RST_DATA_BURST, RST_ZERO_SPACE, RST_ONE_SPACE, RST_IDLE_LIMIT,
                    RST_TOLERANCE, RST_GROUP_BITS, 1'b0, 1'b0};
            state    = FS_IDLE;
            acc      = '0;
            nbits    = 0;
            hdr_last = 1'b0;
            errors   = 0;
        endfunction

        function void note_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] val);
            case (idx)
                REG_DATA_BURST: cfg.data_burst_us     = val;
                REG_ZERO_SPACE: cfg.zero_space_us     = val;
                REG_ONE_SPACE:  cfg.one_space_us      = val;
                REG_IDLE_LIMIT: cfg.idle_limit_ms     = val[IDLE_W-1:0];
                REG_TOLERANCE:  cfg.tolerance_percent = val[TOL_W-1:0];
                REG_GROUP_BITS: cfg.group_bits        = val[GRP_W-1:0];
                REG_SKIP_HDR:   cfg.skip_header       = val[0];
                REG_SHIFT_PACK: cfg.shift_packing     = val[0];
                default: ;
            endcase
        endfunction

        function bit under_band(longint unsigned w, longint unsigned nom);
            longint unsigned f;
            f = (cfg.tolerance_percent > 100) ? 0 : 100 - cfg.tolerance_percent;
            return w * 100 < nom * f;
        endfunction

        function bit over_band(longint unsigned w, longint unsigned nom);
            return w * 100 > nom * (100 + longint'(cfg.tolerance_percent));
        endfunction

        function bit in_band(longint unsigned w, longint unsigned nom);
            return !under_band(w, nom) && !over_band(w, nom);
        endfunction

        function logic [PT_W-1:0] classify(bit mark, longint unsigned w);
            longint unsigned lo_nom;
            longint unsigned hi_nom;
            lo_nom = cfg.data_burst_us;
            if (cfg.zero_space_us < lo_nom) lo_nom = cfg.zero_space_us;
            if (cfg.one_space_us < lo_nom) lo_nom = cfg.one_space_us;
            hi_nom = (cfg.one_space_us > cfg.zero_space_us) ? cfg.one_space_us
                                                            : cfg.zero_space_us;
            if (under_band(w, lo_nom)) return PT_INVALID;
            if (mark) begin
                if (in_band(w, cfg.data_burst_us)) return PT_DATA;
                if (over_band(w, cfg.data_burst_us)) return PT_LONG_BURST;
                return PT_INVALID;
            end
            if (w >= longint'(cfg.idle_limit_ms) * 1000) return PT_IDLE;
            if (in_band(w, cfg.zero_space_us)) return PT_BIT0;
            if (in_band(w, cfg.one_space_us)) return PT_BIT1;
            if (over_band(w, hi_nom)) return PT_LONG_SPACE;
            return PT_INVALID;
        endfunction

        function void push(logic [KIND_W-1:0] kind, logic [OUT_W-1:0] word);
            t_result r;
            r.kind = kind;
            r.word = word;
            r.last = 1'b0;
            step_out.push_back(r);
        endfunction

        // pending bits are flushed as unknown before any symbol
        function void emit_symbol(logic [KIND_W-1:0] kind);
            if (kind == K_HEADER && hdr_last) return;
            if (nbits > 0) begin
                push(K_UNKNOWN, '0);
                acc   = '0;
                nbits = 0;
            end
            push(kind, '0);
            hdr_last = (kind == K_HEADER);
        endfunction

        function void shift_in(bit b);
            int unsigned g;
            g = cfg.group_bits;
            if (g == 0) g = 8;
            if (g > WORD_WIDTH) g = WORD_WIDTH;
            state = FS_DATA_WAIT;
            if (cfg.shift_packing) begin
                acc = {acc[WORD_WIDTH-2:0], b};
            end else if (nbits < WORD_WIDTH && b) begin
                acc[nbits] = 1'b1;
            end
            nbits++;
            if (nbits >= g) begin
                push(K_DATA, acc);
                acc      = '0;
                nbits    = 0;
                hdr_last = 1'b0;
            end
        endfunction

        function void decode_pulse(bit mark, logic [PW_W-1:0] w);
            logic [PT_W-1:0] pc;
            bit              is_bit;
            bit              b;
            t_result         r;
            pc     = classify(mark, w);
            is_bit = (pc == PT_BIT0) || (pc == PT_BIT1);
            b      = (pc == PT_BIT1);
            step_out.delete();
            case (state)
                FS_IDLE, FS_HDR_STARTED: begin
                    if (state == FS_HDR_STARTED && pc == PT_IDLE) begin
                        state = FS_IDLE;
                        emit_symbol(K_SPACE);
                    end else if (pc == PT_LONG_SPACE || pc == PT_DATA) begin
                        state = FS_HDR_SYNCED;
                        emit_symbol(K_HEADER);
                    end else if (state == FS_IDLE && pc == PT_LONG_BURST) begin
                        state = FS_HDR_STARTED;
                    end else if (is_bit) begin
                        if (cfg.skip_header) begin
                            shift_in(b);
                        end else begin
                            state = FS_HDR_SYNCED;
                            emit_symbol(K_HEADER);
                        end
                    end
                end
                FS_HDR_SYNCED: begin
                    if (pc == PT_IDLE) begin
                        state = FS_IDLE;
                        emit_symbol(K_SPACE);
                    end else if (is_bit) begin
                        shift_in(b);
                    end
                end
                FS_DATA_WAIT: begin
                    if (pc == PT_IDLE) begin
                        state = FS_IDLE;
                        emit_symbol(K_SPACE);
                    end else if (pc == PT_DATA) begin
                        state = FS_DATA_REC;
                    end else begin
                        state = FS_ERROR;
                    end
                end
                FS_DATA_REC: begin
                    if (pc == PT_IDLE) begin
                        state = FS_IDLE;
                        emit_symbol(K_SPACE);
                    end else if (is_bit) begin
                        shift_in(b);
                    end else begin
                        state = FS_ERROR;
                        emit_symbol(K_UNKNOWN);
                    end
                end
                default: begin
                    state = FS_ERROR;
                    if (pc == PT_IDLE) begin
                        state = FS_IDLE;
                        emit_symbol(K_SPACE);
                    end
                end
            endcase
            if (step_out.size() > 0) begin
                r      = step_out.pop_back();
                r.last = 1'b1;
                step_out.push_back(r);
            end
            foreach (step_out[i]) expected_symbols.push_back(step_out[i]);
        endfunction

        function void check_symbol(logic [KIND_W-1:0] kind, logic [OUT_W-1:0] word,
                                   logic last);
            t_result want;
            if (expected_symbols.size() == 0) begin
                $error("unexpected result: kind %0d word %h last %0d", kind, word, last);
                errors++;
                return;
            end
            want = expected_symbols.pop_front();
            if (kind !== want.kind) begin
                $error("kind: expected %0d, got %0d", want.kind, kind);
                errors++;
            end
            if (word !== want.word) begin
                $error("word: expected %h, got %h", want.word, word);
                errors++;
            end
            if (last !== want.last) begin
                $error("last: expected %0d, got %0d", want.last, last);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    irpd_pulse_if  pulse_if ();
    irpd_result_if result_if ();
    irpd_cfg_if    cfg_if ();

    ir_pulse_distance_decoder_top i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_pulse (pulse_if),
        .i_cfg   (cfg_if),
        .o_result(result_if)
    );

    ir_symbol_scoreboard sb;
    int send_idle_pct;
    int stall_pct;
    int hold_req;
    int hold_left;
    int items_sent;
    int frame_pos;
    int garble_pos;
    t_cfg phase_cfg [1:5];

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    // transaction monitors
    always @(posedge clk) begin
        if (rst_n) begin
            if (pulse_if.valid && pulse_if.ready)
                sb.decode_pulse(pulse_if.is_mark, pulse_if.pulse_width);
            if (cfg_if.valid && cfg_if.ready)
                sb.note_register(cfg_if.index, cfg_if.data);
            if (result_if.valid && result_if.ready)
                sb.check_symbol(result_if.kind, result_if.word, result_if.last);
        end
    end

    // receiver back-pressure, with a long hold-off on request
    always @(negedge clk) begin
        if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            result_if.ready <= 1'b0;
        end else begin
            result_if.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    function automatic logic [PW_W-1:0] clip_width(longint w);
        if (w < 0) return '0;
        if (w > longint'(24'hFFFFFF)) return 24'hFFFFFF;
        return w[PW_W-1:0];
    endfunction

    function automatic longint band_top(longint nom);
        return nom * (100 + longint'(sb.cfg.tolerance_percent)) / 100;
    endfunction

    function automatic logic [PW_W-1:0] near_width(longint nom);
        longint tol;
        longint span;
        tol  = (sb.cfg.tolerance_percent > 100) ? 100 : sb.cfg.tolerance_percent;
        span = nom * tol / 200;
        return clip_width(nom - span + longint'($urandom_range(2 * span)));
    endfunction

    function automatic logic [PW_W-1:0] long_burst_width();
        return clip_width(band_top(sb.cfg.data_burst_us) + 1 + longint'($urandom_range(9000)));
    endfunction

    function automatic logic [PW_W-1:0] long_space_width();
        longint hi_nom;
        hi_nom = (sb.cfg.one_space_us > sb.cfg.zero_space_us) ? sb.cfg.one_space_us
                                                              : sb.cfg.zero_space_us;
        return clip_width(band_top(hi_nom) + 1 + longint'($urandom_range(3000)));
    endfunction

    function automatic logic [PW_W-1:0] idle_width();
        return clip_width(longint'(sb.cfg.idle_limit_ms) * 1000
                          + longint'($urandom_range(5000)));
    endfunction

    function automatic logic [PW_W-1:0] noise_width();
        longint nom;
        longint tol;
        longint edge_w;
        case ($urandom_range(2))
            0:       nom = sb.cfg.data_burst_us;
            1:       nom = sb.cfg.zero_space_us;
            default: nom = sb.cfg.one_space_us;
        endcase
        tol = (sb.cfg.tolerance_percent > 100) ? 100 : sb.cfg.tolerance_percent;
        case ($urandom_range(3))
            0: return PW_W'($urandom());
            1: return PW_W'($urandom_range(3000));
            2: begin
                // just inside or just outside a band edge
                edge_w = $urandom_range(1) ? band_top(nom) : nom * (100 - tol) / 100;
                return clip_width(edge_w + longint'($urandom_range(2)) - 1);
            end
            default: return near_width(nom);
        endcase
    endfunction

    task automatic send_pulse(input bit mark, input logic [PW_W-1:0] w);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct) begin
            pulse_if.valid <= 1'b0;
            @(negedge clk);
        end
        pulse_if.valid       <= 1'b1;
        pulse_if.is_mark     <= mark;
        pulse_if.pulse_width <= w;
        @(posedge clk);
        while (!pulse_if.ready) @(posedge clk);
        items_sent++;
    endtask

    task automatic frame_pulse(input bit mark, input logic [PW_W-1:0] w);
        if (frame_pos == garble_pos) send_pulse(1'($urandom_range(1)), noise_width());
        else send_pulse(mark, w);
        frame_pos++;
    endtask

    task automatic send_frame(input bit with_hdr, input int nb, input bit garble);
        frame_pos  = 0;
        garble_pos = garble ? $urandom_range(2 * nb + 3) : -1;
        if (with_hdr) begin
            frame_pulse(1'b1, long_burst_width());
            frame_pulse(1'b0, long_space_width());
        end
        for (int i = 0; i < nb; i++) begin
            if (with_hdr || i > 0) frame_pulse(1'b1, near_width(sb.cfg.data_burst_us));
            frame_pulse(1'b0, $urandom_range(1) ? near_width(sb.cfg.one_space_us)
                                                : near_width(sb.cfg.zero_space_us));
        end
        frame_pulse(1'b1, near_width(sb.cfg.data_burst_us));
        frame_pulse(1'b0, idle_width());
    endtask

    task automatic random_traffic(input int n);
        int target;
        int nb;
        target = items_sent + n;
        while (items_sent < target) begin
            if ($urandom_range(99) < 70) begin
                nb = ($urandom_range(9) == 0) ? $urandom_range(40, 24) : $urandom_range(17);
                send_frame(!(sb.cfg.skip_header && $urandom_range(1)), nb,
                           $urandom_range(99) < 15);
            end else begin
                send_pulse(1'($urandom_range(1)), noise_width());
            end
        end
    endtask

    task automatic drain_results();
        @(negedge clk);
        pulse_if.valid <= 1'b0;
        while (sb.expected_symbols.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DAT_W-1:0] val);
        @(negedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        @(posedge clk);
        while (!cfg_if.ready) @(posedge clk);
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic apply_config(input t_cfg c);
        write_reg(REG_DATA_BURST, c.data_burst_us);
        write_reg(REG_ZERO_SPACE, c.zero_space_us);
        write_reg(REG_ONE_SPACE, c.one_space_us);
        write_reg(REG_IDLE_LIMIT, CFG_DAT_W'(c.idle_limit_ms));
        write_reg(REG_TOLERANCE, CFG_DAT_W'(c.tolerance_percent));
        write_reg(REG_GROUP_BITS, CFG_DAT_W'(c.group_bits));
        write_reg(REG_SKIP_HDR, CFG_DAT_W'(c.skip_header));
        write_reg(REG_SHIFT_PACK, CFG_DAT_W'(c.shift_packing));
    endtask

    task automatic directed_pulses();
        logic [7:0] pattern;
        pattern = 8'b1011_0010;
        send_pulse(1'b1, '0);
        send_pulse(1'b1, 24'hFFFFFF);
        send_pulse(1'b0, 24'hFFFFFF);
        send_pulse(1'b0, '0);
        send_pulse(1'b1, 24'd9000);
        send_pulse(1'b0, 24'd4500);
        for (int i = 0; i < 8; i++) begin
            send_pulse(1'b1, 24'd560);
            send_pulse(1'b0, pattern[i] ? 24'd1690 : 24'd560);
        end
        // one pending bit, then a malformed space
        send_pulse(1'b1, 24'd560);
        send_pulse(1'b0, 24'd1690);
        send_pulse(1'b1, 24'd560);
        send_pulse(1'b0, 24'd900);
        send_pulse(1'b0, 24'd560);
        send_pulse(1'b0, 24'd20000);
    endtask

    initial begin
        sb                   = new();
        rst_n                = 1'b0;
        pulse_if.valid       = 1'b0;
        pulse_if.is_mark     = 1'b0;
        pulse_if.pulse_width = '0;
        cfg_if.valid         = 1'b0;
        cfg_if.index         = '0;
        cfg_if.data          = '0;
        result_if.ready      = 1'b0;
        send_idle_pct        = 0;
        stall_pct            = 0;
        hold_req             = 0;
        hold_left            = 0;
        items_sent           = 0;
        frame_pos            = 0;
        garble_pos           = -1;

        phase_cfg[1] = '{16'd300, 16'd400, 16'd1200, 10'd5, 7'd10, 6'd32, 1'b1, 1'b1};
        phase_cfg[2] = '{16'd600, 16'd600, 16'd1800, 10'd6, 7'd0, 6'd5, 1'b0, 1'b1};
        phase_cfg[3] = '{16'hFFFF, 16'hFFFF, 16'd0, 10'd1023, 7'd127, 6'd63, 1'b1, 1'b0};
        phase_cfg[4] = '{16'd0, 16'd0, 16'd0, 10'd0, 7'd100, 6'd0, 1'b0, 1'b0};
        phase_cfg[5] = '{16'd560, 16'd560, 16'd1690, 10'd10, 7'd30, 6'd1, 1'b0, 1'b0};

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        directed_pulses();
        random_traffic(30);

        drain_results();
        apply_config(phase_cfg[1]);
        send_idle_pct = 49;
        random_traffic(15);
        drain_results();
        random_traffic(15);

        drain_results();
        apply_config(phase_cfg[2]);
        send_idle_pct = 0;
        stall_pct     = 49;
        random_traffic(35);

        drain_results();
        apply_config(phase_cfg[3]);
        send_idle_pct = 26;
        stall_pct     = 26;
        random_traffic(35);

        drain_results();
        apply_config(phase_cfg[4]);
        send_idle_pct = 0;
        stall_pct     = 49;
        random_traffic(35);

        // output held off while a long one-bit-per-word frame keeps coming
        drain_results();
        apply_config(phase_cfg[5]);
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_req      = 400;
        send_pulse(1'b0, idle_width());
        send_frame(1'b1, 40, 1'b0);
        send_idle_pct = 26;
        stall_pct     = 26;
        random_traffic(35);

        drain_results();
        if (sb.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

FILE: sim.f
design/irpd_pkg.sv
design/irpd_if.sv
design/irpd_cfg_regs.sv
design/irpd_classify.sv
design/irpd_frame_fsm.sv
design/irpd_out_queue.sv
design/ir_pulse_distance_decoder_top.sv
sim/tb_ir_pulse_distance_decoder_top.sv
